// File: rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and helpers of the Playfair digraph cipher.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // Command codes of an input word
    localparam logic [1:0] CMD_KEY     = 2'd0;
    localparam logic [1:0] CMD_KEY_END = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    // Status codes of a result word
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_KEY   = 3'd1;
    localparam logic [2:0] ST_BAD_TEXT  = 3'd2;
    localparam logic [2:0] ST_NOT_READY = 3'd3;
    localparam logic [2:0] ST_ODD       = 3'd4;

    // Letters as indices from 'a'
    localparam logic [4:0] IDX_I = 5'd8;
    localparam logic [4:0] IDX_J = 5'd9;
    localparam logic [4:0] IDX_X = 5'd23;

    // ASCII bounds
    localparam logic [7:0] ASCII_A = 8'd97;
    localparam logic [7:0] ASCII_J = 8'd106;
    localparam logic [7:0] ASCII_Z = 8'd122;

    // Square geometry
    localparam int         SQ_CELLS    = 25;
    localparam int         ALPHA_SIZE  = 26;
    localparam logic [4:0] CELL_COUNT  = 5'd25;
    localparam logic [4:0] ALPHA_LAST  = 5'd25;
    localparam int         POS_WIDTH   = 6;
    localparam int         QUEUE_DEPTH = 4;

    typedef logic [4:0] letter_t;
    typedef logic [4:0] cell_t;
    typedef logic [2:0] coord_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } pos_t;

    // One unit of work handed from the front to the back
    typedef struct packed {
        logic       is_pair;
        letter_t    a;
        letter_t    b;
        logic [2:0] status;
        logic       last;
    } job_t;

    // Table write from the front: square[slot] = letter, pos[letter] = slot
    typedef struct packed {
        logic    we;
        cell_t   slot;
        letter_t letter;
    } tbl_wr_t;

    // Table reads from the back
    typedef struct packed {
        logic    pos_re;
        letter_t pos_a;
        letter_t pos_b;
        logic    sq_re;
        cell_t   cell_a;
        cell_t   cell_b;
    } tbl_rd_t;

    function automatic pos_t pos_of_cell(input cell_t slot);
        pos_t  p;
        cell_t base;
        if (slot >= 5'd20) begin
            p.row = 3'd4;
            base  = 5'd20;
        end else if (slot >= 5'd15) begin
            p.row = 3'd3;
            base  = 5'd15;
        end else if (slot >= 5'd10) begin
            p.row = 3'd2;
            base  = 5'd10;
        end else if (slot >= 5'd5) begin
            p.row = 3'd1;
            base  = 5'd5;
        end else begin
            p.row = 3'd0;
            base  = 5'd0;
        end
        p.col = coord_t'(slot - base);
        return p;
    endfunction

    function automatic cell_t cell_of(input coord_t row, input coord_t col);
        return cell_t'({2'b00, row} * 5'd5 + {2'b00, col});
    endfunction

    // Move one step along a row or column with wrap; decrypt steps back
    function automatic coord_t step_coord(input coord_t v, input logic dec);
        logic [3:0] s;
        s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
        if (s >= 4'd5)
            s = s - 4'd5;
        return s[2:0];
    endfunction

endpackage

// File: rtl/playfair_digraph_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// Playfair cipher on lowercase ASCII with a streamed key and 5x5 square.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Word
//  -------  ---------  ---------------------  ----------------------------------
//  input    in         in_valid / in_stall    cmd, letter, text_end
//  output   out        out_valid / out_stall  first_out, second_out, pair_valid,
//                                             status, last_of_run
//  config   in         cfg_valid / cfg_ready  cfg_data (decrypt_mode)
//
//  The front takes one input word per cycle while the job queue has room for
//  two jobs; a doubled final pair holds the input while state F_PEND queues
//  its second job. Key words wait until the queue and the back are empty,
//  and end of key runs a sweep that places the unused letters.
//  The back takes three steps per pair result word: pop with position
//  lookup, square lookup, load of the result register; the position read
//  and the square read lie in series. Status words skip the lookups.
//  Reset clears control and output state; the square needs no clearing pass.
//  A stalled result word holds in its register while the front keeps
//  accepting into the queue.
//
module playfair_digraph_cipher #(
    parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] letter,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] first_out,
    output logic [7:0] second_out,
    output logic       pair_valid,
    output logic [2:0] status,
    output logic       last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import pfc_pkg::*;

    logic    decrypt_mode_reg;
    logic    push;
    job_t    push_job;
    logic    pop;
    job_t    q_head;
    logic    q_empty;
    logic    q_room2;
    logic    back_busy;
    logic    drained;
    tbl_wr_t tbl_wr;
    tbl_rd_t tbl_rd;
    logic [4:0]           sq_rdata_a;
    logic [4:0]           sq_rdata_b;
    logic [POS_WIDTH-1:0] pos_rdata_a;
    logic [POS_WIDTH-1:0] pos_rdata_b;

    // The user must write the mode register only while the block is idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            decrypt_mode_reg <= cfg_data;
        end
    end

    // Key updates rewrite the square, so they wait for all lookups to finish
    assign drained = q_empty && !back_busy;

    pfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .letter   (letter),
        .text_end (text_end),
        .decrypt  (decrypt_mode_reg),
        .q_room2  (q_room2),
        .drained  (drained),
        .push     (push),
        .push_job (push_job),
        .tbl_wr   (tbl_wr)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .room2    (q_room2)
    );

    // Square: slot -> letter
    pfc_ram #(
        .WIDTH (5),
        .DEPTH (SQ_CELLS)
    ) u_sq_ram (
        .clk     (clk),
        .we      (tbl_wr.we),
        .waddr   (tbl_wr.slot),
        .wdata   (tbl_wr.letter),
        .re      (tbl_rd.sq_re),
        .raddr_a (tbl_rd.cell_a),
        .raddr_b (tbl_rd.cell_b),
        .rdata_a (sq_rdata_a),
        .rdata_b (sq_rdata_b)
    );

    // Inverse table: letter -> row and column
    pfc_ram #(
        .WIDTH (POS_WIDTH),
        .DEPTH (ALPHA_SIZE)
    ) u_pos_ram (
        .clk     (clk),
        .we      (tbl_wr.we),
        .waddr   (tbl_wr.letter),
        .wdata   (pos_of_cell(tbl_wr.slot)),
        .re      (tbl_rd.pos_re),
        .raddr_a (tbl_rd.pos_a),
        .raddr_b (tbl_rd.pos_b),
        .rdata_a (pos_rdata_a),
        .rdata_b (pos_rdata_b)
    );

    pfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .decrypt     (decrypt_mode_reg),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .pop         (pop),
        .busy        (back_busy),
        .tbl_rd      (tbl_rd),
        .sq_rdata_a  (sq_rdata_a),
        .sq_rdata_b  (sq_rdata_b),
        .pos_rdata_a (pos_rdata_a),
        .pos_rdata_b (pos_rdata_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_out   (first_out),
        .second_out  (second_out),
        .pair_valid  (pair_valid),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

// File: rtl/pfc_ram.sv
// ----------------------------------------------------------------------------
// pfc_ram
// Generic RAM, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: rtl/pfc_queue.sv
// ----------------------------------------------------------------------------
// pfc_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module pfc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pfc_pkg::job_t push_job,
    input  logic          pop,
    output pfc_pkg::job_t head,
    output logic          empty,
    output logic          room2
);
    import pfc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = slots[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign room2 = (count_reg <= CW'(DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("job popped from an empty queue");

endmodule

// File: rtl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Accepts input words, builds the key square and pairs text letters.
// ----------------------------------------------------------------------------
module pfc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       cmd,
    input  logic [7:0]       letter,
    input  logic             text_end,
    input  logic             decrypt,
    input  logic             q_room2,
    input  logic             drained,
    output logic             push,
    output pfc_pkg::job_t    push_job,
    output pfc_pkg::tbl_wr_t tbl_wr
);
    import pfc_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PEND,
        F_FILL
    } fstate_t;

    fstate_t     state_reg, state_next;
    logic [25:0] marks_reg, marks_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [4:0]  sweep_reg, sweep_next;
    logic        ready_reg, ready_next;
    logic        rej_reg, rej_next;
    letter_t     held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    job_t        pend_reg, pend_next;

    logic        accept;
    logic        key_cmd;
    logic        is_letter;
    logic [7:0]  diff;
    letter_t     idx;
    letter_t     text_idx;
    logic [25:0] eff_marks;
    logic [4:0]  eff_cnt;
    logic        eff_rej;

    always_comb
    begin
        key_cmd   = (cmd == CMD_KEY) || (cmd == CMD_KEY_END);
        in_stall  = !((state_reg == F_IDLE) && q_room2 && (!key_cmd || drained));
        accept    = in_valid && !in_stall;
        is_letter = letter inside {[ASCII_A:ASCII_Z]};
        diff      = letter - ASCII_A;
        idx       = is_letter ? diff[4:0] : '0;
        text_idx  = (idx == IDX_J) ? IDX_I : idx;
        eff_marks = ready_reg ? '0 : marks_reg;
        eff_cnt   = ready_reg ? '0 : cnt_reg;
        eff_rej   = ready_reg ? 1'b0 : rej_reg;

        state_next      = state_reg;
        marks_next      = marks_reg;
        cnt_next        = cnt_reg;
        sweep_next      = sweep_reg;
        ready_next      = ready_reg;
        rej_next        = rej_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_job        = '0;
        tbl_wr          = '0;

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_KEY:
                        begin
                            // Key letter after a finished key starts a new key
                            marks_next = eff_marks;
                            cnt_next   = eff_cnt;
                            rej_next   = eff_rej;
                            ready_next = 1'b0;
                            if (ready_reg)
                            begin
                                held_valid_next = 1'b0;
                            end
                            if (!eff_rej)
                            begin
                                if (!is_letter)
                                begin
                                    rej_next        = 1'b1;
                                    push            = 1'b1;
                                    push_job.status = ST_BAD_KEY;
                                    push_job.last   = 1'b1;
                                end
                                else if (idx != IDX_J && !eff_marks[idx]
                                         && eff_cnt < CELL_COUNT)
                                begin
                                    tbl_wr.we     = 1'b1;
                                    tbl_wr.slot   = eff_cnt;
                                    tbl_wr.letter = idx;
                                    marks_next    = eff_marks | (26'd1 << idx);
                                    cnt_next      = eff_cnt + 5'd1;
                                end
                            end
                        end
                        CMD_KEY_END:
                        begin
                            if (!ready_reg)
                            begin
                                held_valid_next = 1'b0;
                                if (rej_reg)
                                begin
                                    marks_next      = '0;
                                    cnt_next        = '0;
                                    rej_next        = 1'b0;
                                    push            = 1'b1;
                                    push_job.status = ST_BAD_KEY;
                                    push_job.last   = 1'b1;
                                end
                                else
                                begin
                                    sweep_next = '0;
                                    state_next = F_FILL;
                                end
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (!ready_reg)
                            begin
                                push            = 1'b1;
                                push_job.status = ST_NOT_READY;
                                push_job.last   = 1'b1;
                            end
                            else if (!is_letter)
                            begin
                                held_valid_next = 1'b0;
                                push            = 1'b1;
                                push_job.status = ST_BAD_TEXT;
                                push_job.last   = 1'b1;
                            end
                            else if (decrypt)
                            begin
                                if (held_valid_reg)
                                begin
                                    held_valid_next  = 1'b0;
                                    push             = 1'b1;
                                    push_job.is_pair = 1'b1;
                                    push_job.a       = held_reg;
                                    push_job.b       = text_idx;
                                    push_job.status  = ST_OK;
                                    push_job.last    = 1'b1;
                                end
                                else if (text_end)
                                begin
                                    push            = 1'b1;
                                    push_job.status = ST_ODD;
                                    push_job.last   = 1'b1;
                                end
                                else
                                begin
                                    held_next       = text_idx;
                                    held_valid_next = 1'b1;
                                end
                            end
                            else if (!held_valid_reg)
                            begin
                                if (text_end)
                                begin
                                    push             = 1'b1;
                                    push_job.is_pair = 1'b1;
                                    push_job.a       = text_idx;
                                    push_job.b       = IDX_X;
                                    push_job.last    = 1'b1;
                                end
                                else
                                begin
                                    held_next       = text_idx;
                                    held_valid_next = 1'b1;
                                end
                            end
                            else if (held_reg == text_idx)
                            begin
                                // Repeat: split with x and keep the letter held; at text end queue it with x too
                                push             = 1'b1;
                                push_job.is_pair = 1'b1;
                                push_job.a       = held_reg;
                                push_job.b       = IDX_X;
                                push_job.last    = !text_end;
                                if (text_end)
                                begin
                                    held_valid_next   = 1'b0;
                                    pend_next         = '0;
                                    pend_next.is_pair = 1'b1;
                                    pend_next.a       = text_idx;
                                    pend_next.b       = IDX_X;
                                    pend_next.last    = 1'b1;
                                    state_next        = F_PEND;
                                end
                            end
                            else
                            begin
                                held_valid_next  = 1'b0;
                                push             = 1'b1;
                                push_job.is_pair = 1'b1;
                                push_job.a       = held_reg;
                                push_job.b       = text_idx;
                                push_job.last    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            F_PEND:
            begin
                push       = 1'b1;
                push_job   = pend_reg;
                state_next = F_IDLE;
            end
            F_FILL:
            begin
                // Place unused letters in alphabetical order, one per cycle
                if (sweep_reg != IDX_J && !marks_reg[sweep_reg] && cnt_reg < CELL_COUNT)
                begin
                    tbl_wr.we     = 1'b1;
                    tbl_wr.slot   = cnt_reg;
                    tbl_wr.letter = sweep_reg;
                    marks_next    = marks_reg | (26'd1 << sweep_reg);
                    cnt_next      = cnt_reg + 5'd1;
                end
                if (sweep_reg == ALPHA_LAST)
                begin
                    ready_next = 1'b1;
                    state_next = F_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= F_IDLE;
            marks_reg      <= '0;
            cnt_reg        <= '0;
            sweep_reg      <= '0;
            ready_reg      <= 1'b0;
            rej_reg        <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            marks_reg      <= marks_next;
            cnt_reg        <= cnt_next;
            sweep_reg      <= sweep_next;
            ready_reg      <= ready_next;
            rej_reg        <= rej_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (cnt_reg == CELL_COUNT))
        else $error("key square marked ready while not full");

endmodule

// File: rtl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Carries out queued jobs: square lookups and the result register.
// ----------------------------------------------------------------------------
module pfc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             decrypt,
    input  logic             q_empty,
    input  pfc_pkg::job_t    q_head,
    output logic             pop,
    output logic             busy,
    output pfc_pkg::tbl_rd_t tbl_rd,
    input  logic [4:0]       sq_rdata_a,
    input  logic [4:0]       sq_rdata_b,
    input  logic [5:0]       pos_rdata_a,
    input  logic [5:0]       pos_rdata_b,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       first_out,
    output logic [7:0]       second_out,
    output logic             pair_valid,
    output logic [2:0]       status,
    output logic             last_of_run
);
    import pfc_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOOK,
        B_EMIT
    } bstate_t;

    bstate_t    state_reg;
    job_t       job_reg;
    logic       out_valid_reg;
    logic [7:0] first_reg;
    logic [7:0] second_reg;
    logic       pair_valid_reg;
    logic [2:0] status_reg;
    logic       last_reg;
    logic       out_free;
    pos_t       pa;
    pos_t       pb;
    cell_t      na;
    cell_t      nb;

    assign out_valid   = out_valid_reg;
    assign first_out   = first_reg;
    assign second_out  = second_reg;
    assign pair_valid  = pair_valid_reg;
    assign status      = status_reg;
    assign last_of_run = last_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign pop         = (state_reg == B_IDLE) && !q_empty;
    assign busy        = (state_reg != B_IDLE);

    always_comb
    begin
        pa = pos_t'(pos_rdata_a);
        pb = pos_t'(pos_rdata_b);
        if (pa.row == pb.row)
        begin
            na = cell_of(pa.row, step_coord(pa.col, decrypt));
            nb = cell_of(pb.row, step_coord(pb.col, decrypt));
        end
        else if (pa.col == pb.col)
        begin
            na = cell_of(step_coord(pa.row, decrypt), pa.col);
            nb = cell_of(step_coord(pb.row, decrypt), pb.col);
        end
        else
        begin
            na = cell_of(pa.row, pb.col);
            nb = cell_of(pb.row, pa.col);
        end

        tbl_rd.pos_re = pop && q_head.is_pair;
        tbl_rd.pos_a  = q_head.a;
        tbl_rd.pos_b  = q_head.b;
        tbl_rd.sq_re  = (state_reg == B_LOOK);
        tbl_rd.cell_a = na;
        tbl_rd.cell_b = nb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            job_reg        <= '0;
            out_valid_reg  <= 1'b0;
            first_reg      <= '0;
            second_reg     <= '0;
            pair_valid_reg <= 1'b0;
            status_reg     <= ST_OK;
            last_reg       <= 1'b0;
        end
        else
        begin
            // Load a new result word, or drop the current one once taken
            if ((state_reg == B_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        job_reg   <= q_head;
                        state_reg <= q_head.is_pair ? B_LOOK : B_EMIT;
                    end
                end
                B_LOOK:
                begin
                    state_reg <= B_EMIT;
                end
                B_EMIT:
                begin
                    // Hold until the result register is free
                    if (out_free)
                    begin
                        pair_valid_reg <= job_reg.is_pair;
                        status_reg     <= job_reg.status;
                        last_reg       <= job_reg.last;
                        if (job_reg.is_pair)
                        begin
                            first_reg  <= {3'b000, sq_rdata_a} + ASCII_A;
                            second_reg <= {3'b000, sq_rdata_b} + ASCII_A;
                        end
                        else
                        begin
                            first_reg  <= '0;
                            second_reg <= '0;
                        end
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pair_valid_reg) |-> (status_reg == ST_OK))
        else $error("pair result carries an error status");

    a_no_j: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pair_valid_reg) |-> (first_reg != ASCII_J && second_reg != ASCII_J))
        else $error("square lookup returned the letter j");

endmodule

// File: dv/tb_playfair_digraph_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_playfair_digraph_cipher
// Self-checking bench for the Playfair digraph cipher. A cycle-free model of
// the key square, the letter pairing and both cipher directions predicts
// every result word; a checker compares each word field by field as it
// leaves the block. Directed words hit the key and text corner cases, then
// random keys and messages run under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_playfair_digraph_cipher;
    import pfc_pkg::*;

    // cmd value with no meaning; the block must drop it silently
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         WORD_TARGET  = 1200;
    // Idle time before a mode write: covers the fill sweep after
    // end of key plus the back end finishing its last word
    localparam int         DRAIN_CYCLES = 60;
    // Cycles without any handshake before the run is declared hung
    localparam int         HANG_LIMIT   = 2000;
    localparam int         MAX_PRINTS   = 40;

    // One result word as it appears on the output ports
    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic       pair_ok;
        logic [2:0] code;
        logic       last;
    } pair_word_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [1:0] cmd        = CMD_TEXT;
    logic [7:0] letter     = 8'h00;
    logic       text_end   = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [7:0] first_out;
    logic [7:0] second_out;
    logic       pair_valid;
    logic [2:0] status;
    logic       last_of_run;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic       cfg_data   = 1'b0;

    always #5 clk = ~clk;

    playfair_digraph_cipher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .letter      (letter),
        .text_end    (text_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .first_out   (first_out),
        .second_out  (second_out),
        .pair_valid  (pair_valid),
        .status      (status),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Cipher model state: the square, key bookkeeping and the pairing latch
    // ------------------------------------------------------------------------
    letter_t               square [SQ_CELLS];
    logic [ALPHA_SIZE-1:0] taken_marks  = '0;
    int                    fill_count   = 0;
    bit                    square_ready = 1'b0;
    bit                    key_bad      = 1'b0;
    letter_t               held_letter  = '0;
    bit                    held_valid   = 1'b0;
    bit                    decrypt_mode = 1'b0;

    // Words the block still owes us, oldest first
    pair_word_t cipher_queue [$];

    // Knobs for the random idling of each side (0 means run flat out)
    int gap_max     = 0;
    int stall_max   = 0;
    int stall_left  = 0;
    int stall_drawn = 0;

    int words_sent    = 0;
    int words_checked = 0;
    int keys_loaded   = 0;
    int mode_writes   = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    initial begin
        for (int n = 0; n < SQ_CELLS; n++)
            square[n] = '0;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------
    function automatic void restart_key();
        taken_marks  = '0;
        fill_count   = 0;
        square_ready = 1'b0;
        key_bad      = 1'b0;
        held_valid   = 1'b0;
    endfunction

    function automatic void place_letter(input letter_t idx);
        square[fill_count] = idx;
        taken_marks[idx]   = 1'b1;
        fill_count++;
    endfunction

    function automatic void push_status(input logic [2:0] code);
        pair_word_t w;
        w         = '0;
        w.code    = code;
        w.last    = 1'b1;
        cipher_queue.insert(cipher_queue.size(), w);
    endfunction

    // Position of a letter in the square; first hit wins
    function automatic int where_is(input letter_t idx);
        for (int p = 0; p < SQ_CELLS; p++)
            if (square[p] == idx)
                return p;
        return 0;
    endfunction

    // Apply the row, column or rectangle rule to one pair
    function automatic void push_pair(input letter_t a, input letter_t b, input logic last);
        pair_word_t w;
        int         pa;
        int         pb;
        int         shift;
        int         na;
        int         nb;
        pa    = where_is(a);
        pb    = where_is(b);
        shift = decrypt_mode ? 4 : 1;
        if (pa / 5 == pb / 5) begin
            na = (pa / 5) * 5 + (pa % 5 + shift) % 5;
            nb = (pb / 5) * 5 + (pb % 5 + shift) % 5;
        end else if (pa % 5 == pb % 5) begin
            na = ((pa / 5 + shift) % 5) * 5 + pa % 5;
            nb = ((pb / 5 + shift) % 5) * 5 + pb % 5;
        end else begin
            na = (pa / 5) * 5 + pb % 5;
            nb = (pb / 5) * 5 + pa % 5;
        end
        w.first   = ASCII_A + 8'(square[na]);
        w.second  = ASCII_A + 8'(square[nb]);
        w.pair_ok = 1'b1;
        w.code    = ST_OK;
        w.last    = last;
        cipher_queue.insert(cipher_queue.size(), w);
    endfunction

    // Advance the model by one accepted input word; return 1 if ignored
    function automatic bit predict_word(input logic [1:0] c, input logic [7:0] ch,
                                        input logic te);
        bit      is_letter;
        letter_t idx;
        is_letter = (ch >= ASCII_A) && (ch <= ASCII_Z);
        idx       = is_letter ? letter_t'(ch - ASCII_A) : letter_t'(0);
        case (c)
            CMD_KEY: begin
                if (square_ready)
                    restart_key();
                if (key_bad)
                    return 1'b1;
                if (!is_letter) begin
                    key_bad = 1'b1;
                    push_status(ST_BAD_KEY);
                end else if (idx != IDX_J && !taken_marks[idx] && fill_count < SQ_CELLS)
                    place_letter(idx);
                return 1'b0;
            end
            CMD_KEY_END: begin
                if (square_ready)
                    return 1'b1;
                if (key_bad) begin
                    restart_key();
                    push_status(ST_BAD_KEY);
                    return 1'b0;
                end
                for (int n = 0; n < ALPHA_SIZE; n++)
                    if (n != IDX_J && !taken_marks[n] && fill_count < SQ_CELLS)
                        place_letter(letter_t'(n));
                square_ready = 1'b1;
                held_valid   = 1'b0;
                return 1'b0;
            end
            CMD_TEXT: begin
                if (!square_ready) begin
                    push_status(ST_NOT_READY);
                    return 1'b0;
                end
                if (!is_letter) begin
                    held_valid = 1'b0;
                    push_status(ST_BAD_TEXT);
                    return 1'b0;
                end
                if (idx == IDX_J)
                    idx = IDX_I;
                if (decrypt_mode) begin
                    if (held_valid) begin
                        held_valid = 1'b0;
                        push_pair(held_letter, idx, 1'b1);
                    end else if (te)
                        push_status(ST_ODD);
                    else begin
                        held_letter = idx;
                        held_valid  = 1'b1;
                    end
                end else if (!held_valid) begin
                    // Lone final letter gets an x pad
                    if (te)
                        push_pair(idx, IDX_X, 1'b1);
                    else begin
                        held_letter = idx;
                        held_valid  = 1'b1;
                    end
                end else if (held_letter == idx) begin
                    // Split a doubled letter with x; keep the second one held, or pad it with x at the end
                    push_pair(held_letter, IDX_X, !te);
                    if (te) begin
                        held_valid = 1'b0;
                        push_pair(idx, IDX_X, 1'b1);
                    end
                end else begin
                    held_valid = 1'b0;
                    push_pair(held_letter, idx, 1'b1);
                end
                return 1'b0;
            end
            default: return 1'b1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stall per word, then compare with the oldest
    // expectation
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
        mismatches++;
    endtask

    // Draw a fresh stall count after each word taken, then apply it
    always @(negedge clk) begin
        if (words_checked != stall_drawn) begin
            stall_left  = $urandom_range(0, stall_max);
            stall_drawn = words_checked;
        end
        if (out_valid && stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        pair_word_t got;
        pair_word_t want;
        if (rst_n && out_valid && !out_stall) begin
            got        = '{first_out, second_out, pair_valid, status, last_of_run};
            words_checked++;
            if (cipher_queue.size() == 0)
                report_mismatch("unexpected result word", 0, int'(got));
            else begin
                want = cipher_queue.pop_front();
                if (got.first !== want.first)
                    report_mismatch("first_out", want.first, got.first);
                if (got.second !== want.second)
                    report_mismatch("second_out", want.second, got.second);
                if (got.pair_ok !== want.pair_ok)
                    report_mismatch("pair_valid", want.pair_ok, got.pair_ok);
                if (got.code !== want.code)
                    report_mismatch("status", want.code, got.code);
                if (got.last !== want.last)
                    report_mismatch("last_of_run", want.last, got.last);
            end
        end
    end

    // Hang detection: any handshake on any channel resets the count
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == HANG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, HANG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus primitives; each starts and ends on a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] c, input logic [7:0] ch, input logic te);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        letter   <= ch;
        text_end <= te;
        do @(posedge clk); while (in_stall);
        if (!predict_word(c, ch, te))
            words_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every owed word is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (cipher_queue.size() != 0);
    endtask

    task automatic write_mode(input logic dec);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= dec;
        do @(posedge clk); while (!cfg_ready);
        decrypt_mode = dec;
        mode_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] any_letter();
        return ASCII_A + 8'($urandom_range(0, 25));
    endfunction

    // Bytes around and outside the lowercase range
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return ASCII_A - 8'd1;
            2:       return ASCII_Z + 8'd1;
            3:       return 8'hff;
            4:       return ASCII_A - 8'd32 + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_key();
        logic [7:0] alphabet [26];
        logic [7:0] tmp;
        int         len;
        int         bad_at;
        int         k;
        int         r;
        if ($urandom_range(0, 9) == 0) begin
            // Whole alphabet in shuffled order: the fill adds nothing
            for (k = 0; k < 26; k++)
                alphabet[k] = ASCII_A + 8'(k);
            for (k = 25; k > 0; k--) begin
                r           = $urandom_range(0, k);
                tmp         = alphabet[k];
                alphabet[k] = alphabet[r];
                alphabet[r] = tmp;
            end
            for (k = 0; k < 26; k++)
                send_word(CMD_KEY, alphabet[k], 1'($urandom_range(0, 1)));
        end else begin
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40)
                                                 : $urandom_range(0, 12);
            bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : -1;
            for (k = 0; k < len; k++)
                send_word(CMD_KEY, (k == bad_at) ? noise_byte() : any_letter(),
                          1'($urandom_range(0, 1)));
        end
        send_word(CMD_KEY_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        keys_loaded++;
    endtask

    // Message biased toward doubled letters, j, x and the odd junk byte
    task automatic send_random_message();
        logic [7:0] ch;
        logic [7:0] prev;
        int         len;
        int         pick;
        int         k;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        prev = any_letter();
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 4)
                ch = prev;
            else if (pick == 4)
                ch = "j";
            else if (pick == 5)
                ch = "x";
            else if (pick == 6)
                ch = noise_byte();
            else if (pick == 7)
                ch = "i";
            else
                ch = any_letter();
            if (pick == 8 && $urandom_range(0, 3) == 0)
                send_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_word(CMD_TEXT, ch, k == len - 1);
            prev = ch;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Text before any key, and the unused command
    task automatic test_text_without_key();
        gap_max   = 0;
        stall_max = 0;
        send_word(CMD_TEXT, "a", 1'b0);
        send_word(CMD_UNUSED, 8'hff, 1'b1);
    endtask

    // Uppercase key letter rejects the key; later key letters drop; end of
    // key reports it; text then finds no square
    task automatic test_rejected_key();
        gap_max   = 5;
        stall_max = 5;
        send_word(CMD_KEY, "q", 1'b0);
        send_word(CMD_KEY, "A", 1'b1);
        send_word(CMD_KEY, "b", 1'b0);
        send_word(CMD_KEY_END, 8'h00, 1'b0);
        send_word(CMD_TEXT, "c", 1'b1);
    endtask

    // Key with j and a repeat, a second end of key, then doubled letters,
    // j as i, an xx pair, doubled final pair, odd tail and bad text bytes
    task automatic test_encrypt_rules();
        send_word(CMD_KEY, "z", 1'b0);
        send_word(CMD_KEY, "j", 1'b0);
        send_word(CMD_KEY, "a", 1'b0);
        send_word(CMD_KEY, "z", 1'b0);
        send_word(CMD_KEY_END, 8'h00, 1'b0);
        send_word(CMD_KEY_END, 8'hff, 1'b1);
        send_word(CMD_TEXT, "l", 1'b0);
        send_word(CMD_TEXT, "l", 1'b0);
        send_word(CMD_TEXT, "j", 1'b0);
        send_word(CMD_TEXT, "x", 1'b0);
        send_word(CMD_TEXT, "x", 1'b0);
        send_word(CMD_TEXT, "q", 1'b1);
        send_word(CMD_TEXT, "e", 1'b0);
        send_word(CMD_TEXT, "e", 1'b1);
        send_word(CMD_TEXT, "z", 1'b1);
        send_word(CMD_TEXT, ASCII_Z + 8'd1, 1'b0);
        send_word(CMD_TEXT, "m", 1'b0);
        send_word(CMD_TEXT, ASCII_A - 8'd1, 1'b1);
    endtask

    // Decrypt direction and the odd-length error
    task automatic test_decrypt_rules();
        write_mode(1'b1);
        send_word(CMD_TEXT, "b", 1'b0);
        send_word(CMD_TEXT, "d", 1'b0);
        send_word(CMD_TEXT, "a", 1'b1);
    endtask

    // Random keys and messages, with mode flips between phases
    task automatic test_random_traffic();
        drain_results();
        while (words_sent < WORD_TARGET) begin
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
            if ($urandom_range(0, 3) == 0)
                write_mode(1'($urandom_range(0, 1)));
            if (!square_ready || $urandom_range(0, 5) == 0)
                send_random_key();
            repeat ($urandom_range(1, 4))
                send_random_message();
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_text_without_key();
        test_rejected_key();
        test_encrypt_rules();
        test_decrypt_rules();
        test_random_traffic();

        // Wait out owed words, then watch for strays
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input words over %0d keys and %0d mode writes,",
                 words_sent, keys_loaded, mode_writes);
        $display("checked %0d result words, %0d mismatches.", words_checked, mismatches);
        if (mismatches == 0 && cipher_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: playfair_digraph_cipher.f
rtl/pfc_pkg.sv
rtl/pfc_ram.sv
rtl/pfc_queue.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/playfair_digraph_cipher.sv
dv/tb_playfair_digraph_cipher.sv
